>>> hw/rtl/scha_pkg.sv
// Shared codes, types and the size-class function of the heap allocator core.
// Used by scha_class_map and size_class_heap_allocator_core; no dependencies.
package scha_pkg;

	localparam int CLS_IDX_W = 6;
	localparam int SIZE_W    = 17;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] STAT_REUSED  = 3'd0;
	localparam logic [2:0] STAT_TOP     = 3'd1;
	localparam logic [2:0] STAT_OOM     = 3'd2;
	localparam logic [2:0] STAT_FREED   = 3'd3;
	localparam logic [2:0] STAT_IGNORED = 3'd4;
	localparam logic [2:0] STAT_NOOP    = 3'd5;

	typedef struct packed {
		logic                 hit;
		logic [CLS_IDX_W-1:0] idx;
		logic [SIZE_W-1:0]    size;
	} cls_info_t;

	// class size: alternating 1.5x / 4/3x steps, saturated at 17 bits
	function automatic logic [SIZE_W-1:0] cls_size(input int unsigned min_block,
			input int unsigned idx);
		longint unsigned cs;
		longint unsigned half;
		cs   = longint'(min_block);
		half = 0;
		for (int c = 0; c < 64; c++) begin
			if (c < idx) begin
				if ((c % 2) == 0) half = cs >> 1;
				cs = cs + half;
			end
		end
		if (cs >= (longint'(1) << SIZE_W)) return '1;
		return cs[SIZE_W-1:0];
	endfunction

endpackage

>>> hw/rtl/scha_class_map.sv
// Size-class lookup: rounds a request size up to the first class that fits.
// Depends on scha_pkg (cls_size, cls_info_t).
module scha_class_map #(
	parameter int NUM_CLASSES = 64,
	parameter int MIN_BLOCK   = 8
) (
	input  logic [15:0]                 size,
	output scha_pkg::cls_info_t         info
);

	logic [scha_pkg::SIZE_W-1:0] tbl [NUM_CLASSES];
	logic [NUM_CLASSES-1:0]      fit;

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cls
		localparam logic [scha_pkg::SIZE_W-1:0] SZ = scha_pkg::cls_size(MIN_BLOCK, g);
		assign tbl[g] = SZ;
		assign fit[g] = ({1'b0, size} <= SZ);
	end

	always_comb begin
		info = '0;
		for (int g = NUM_CLASSES - 1; g >= 0; g--) begin
			if (fit[g]) begin
				info.hit  = 1'b1;
				info.idx  = (scha_pkg::CLS_IDX_W)'(g);
				info.size = tbl[g];
			end
		end
	end

endmodule

>>> hw/rtl/size_class_heap_allocator_core.sv
// Top level of the size-class heap allocator: sequencer, list-head and link memories.
// Depends on scha_pkg and scha_class_map.
//
//  channel | signals                                         | dir | word
//  req     | req_valid, req_stall, command, request_size,    | in  | one command
//          | block_address                                   |     |
//  rsp     | rsp_valid, rsp_stall, granted_address,          | out | one result
//          | rounded_size, status                            |     |
//  cfg     | write_enable, register_index, write_data        | in  | one register
//
// One word at a time: a word settled at decode goes back to idle from there, a push or
// an allocation from top goes on through the class head read, and a list pop through
// the head read, then the link read, through the registered memory ports.
// Reset clears the heads' valid bits and sets top to heap_start (64).
// A held rsp word lets the next word be accepted; the sequencer holds in decode
// or at its last step while the output register is full and stalled.
module size_class_heap_allocator_core #(
	parameter int HEAP_ADDR_BITS = 16,
	parameter int NUM_CLASSES    = 64,
	parameter int MIN_BLOCK      = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [15:0] request_size,
	input  logic [15:0] block_address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] granted_address,
	output logic [16:0] rounded_size,
	output logic [2:0]  status,
	input  logic        write_enable,
	input  logic        register_index,
	input  logic [16:0] write_data
);

	localparam int CIW = $clog2(NUM_CLASSES);
	localparam logic [17:0] CAP = (HEAP_ADDR_BITS >= 17) ? 18'h3FFFF
		: (18'd1 << HEAP_ADDR_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEC  = 2'd1;
	localparam logic [1:0] ST_HEAD = 2'd2;
	localparam logic [1:0] ST_LINK = 2'd3;

	logic [1:0]  state_q, state_d;
	logic [1:0]  cmd_q;
	logic [15:0] size_q;
	logic [15:0] addr_q;
	logic [15:0] heap_start_q;
	logic [16:0] heap_limit_q;
	logic [16:0] top_q;
	logic [NUM_CLASSES-1:0] head_vld_q;

	logic [15:0] heads_mem [NUM_CLASSES];
	logic [15:0] link_mem [16384];
	logic [15:0] head_rd_s1;
	logic        head_hit_s1;
	logic [15:0] link_rd_s1;

	logic        rsp_valid_q;
	logic [15:0] rsp_ga_q;
	logic [16:0] rsp_rs_q;
	logic [2:0]  rsp_st_q;

	scha_pkg::cls_info_t ci;
	logic [CIW-1:0] ci_idx;
	logic [15:0]    head_val;
	logic [16:0]    lim;
	logic [15:0]    lo;
	logic [17:0]    nt;
	logic           out_free;

	logic        res_ld;
	logic [15:0] res_ga;
	logic [16:0] res_rs;
	logic [2:0]  res_st;
	logic        top_ld;
	logic [16:0] top_d;
	logic        head_we;
	logic [15:0] head_wd;
	logic        link_we;
	logic        clr;

	scha_class_map #(
		.NUM_CLASSES (NUM_CLASSES),
		.MIN_BLOCK   (MIN_BLOCK)
	) u_class_map (
		.size (size_q),
		.info (ci)
	);

	assign ci_idx   = ci.idx[CIW-1:0];
	assign head_val = head_hit_s1 ? head_rd_s1 : 16'd0;
	assign lim      = ({1'b0, heap_limit_q} < CAP) ? heap_limit_q : CAP[16:0];
	assign lo       = (heap_start_q == 16'd0) ? 16'd1 : heap_start_q;
	assign nt       = {1'b0, top_q} + {1'b0, ci.size};
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall       = (state_q != ST_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign granted_address = rsp_ga_q;
	assign rounded_size    = rsp_rs_q;
	assign status          = rsp_st_q;

	always_comb begin
		state_d = state_q;
		res_ld  = 1'b0;
		res_ga  = 16'd0;
		res_rs  = 17'd0;
		res_st  = scha_pkg::STAT_NOOP;
		top_ld  = 1'b0;
		top_d   = top_q;
		head_we = 1'b0;
		head_wd = addr_q;
		link_we = 1'b0;
		clr     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
					res_ld  = 1'b1;
					case (cmd_q)
						scha_pkg::CMD_ALLOC: begin
							if (size_q == 16'd0) begin
								res_ga = top_q[15:0];
							end else if (!ci.hit) begin
								res_st = scha_pkg::STAT_OOM;
							end else begin
								res_ld  = 1'b0;
								state_d = ST_HEAD;
							end
						end
						scha_pkg::CMD_FREE: begin
							if (size_q == 16'd0) begin
								res_st = scha_pkg::STAT_NOOP;
							end else if (addr_q < lo || {1'b0, addr_q} >= lim || !ci.hit) begin
								res_st = scha_pkg::STAT_IGNORED;
							end else begin
								res_ld  = 1'b0;
								state_d = ST_HEAD;
							end
						end
						scha_pkg::CMD_CLEAR: begin
							clr    = 1'b1;
							top_ld = 1'b1;
							top_d  = {1'b0, heap_start_q};
							res_ga = heap_start_q;
						end
						default: res_st = scha_pkg::STAT_NOOP;
					endcase
				end
			end
			ST_HEAD: begin
				if (cmd_q == scha_pkg::CMD_ALLOC && head_val != 16'd0) begin
					state_d = ST_LINK;
				end else if (out_free) begin
					state_d = ST_IDLE;
					res_ld  = 1'b1;
					res_rs  = ci.size;
					if (cmd_q == scha_pkg::CMD_FREE) begin
						link_we = 1'b1;
						head_we = 1'b1;
						head_wd = addr_q;
						res_ga  = addr_q;
						res_st  = scha_pkg::STAT_FREED;
					end else if (nt > {1'b0, lim}) begin
						res_st = scha_pkg::STAT_OOM;
					end else begin
						top_ld = 1'b1;
						top_d  = nt[16:0];
						res_ga = top_q[15:0];
						res_st = scha_pkg::STAT_TOP;
					end
				end
			end
			ST_LINK: begin
				if (out_free) begin
					state_d = ST_IDLE;
					res_ld  = 1'b1;
					head_we = 1'b1;
					head_wd = link_rd_s1;
					res_ga  = head_val;
					res_rs  = ci.size;
					res_st  = scha_pkg::STAT_REUSED;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			heap_start_q <= 16'd64;
			heap_limit_q <= 17'h10000;
			top_q        <= 17'd64;
			head_vld_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (write_enable) begin
				if (register_index) heap_limit_q <= write_data;
				else heap_start_q <= write_data[15:0];
			end
			if (top_ld) top_q <= top_d;
			if (clr) head_vld_q <= '0;
			else if (head_we) head_vld_q[ci_idx] <= 1'b1;
			if (res_ld) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			cmd_q  <= command;
			size_q <= request_size;
			addr_q <= block_address;
		end
		if (res_ld) begin
			rsp_ga_q <= res_ga;
			rsp_rs_q <= res_rs;
			rsp_st_q <= res_st;
		end
	end

	// list heads: one read, one write port
	always_ff @(posedge clk) begin
		if (head_we) heads_mem[ci_idx] <= head_wd;
		head_rd_s1 <= heads_mem[ci_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) head_hit_s1 <= 1'b0;
		else head_hit_s1 <= head_vld_q[ci_idx];
	end

	// next links, indexed by address / 4
	always_ff @(posedge clk) begin
		if (link_we) link_mem[addr_q[15:2]] <= head_val;
		link_rd_s1 <= link_mem[head_val[15:2]];
	end

endmodule
